FILE: design/btbp_pkg.sv
// -----------------------------------------------------------------------------
// btbp_pkg
// shared types and constants of the branch target buffer predictor
// -----------------------------------------------------------------------------
package btbp_pkg;

   localparam int unsigned ADDR_W    = 32;
   localparam int unsigned IDX_OUT_W = 4;
   localparam int unsigned OFFSET_W  = 16;
   localparam int unsigned STORE_MAX = 16;

   localparam logic [ADDR_W-1:0] PC_STEP = 32'd4;

   localparam logic OP_LOOKUP  = 1'b0;
   localparam logic OP_RESOLVE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

FILE: design/branch_target_buffer_predictor_unit.sv
// -----------------------------------------------------------------------------
// branch_target_buffer_predictor_unit
// direct-mapped branch target buffer, predicts taken on a hit
// -----------------------------------------------------------------------------
// Each item goes in order from transfer in to result shown: the transfer
// cycle reads the tag and target tables, the next cycle compares, installs and
// counts, and then the registered result is presented and held until the
// output transfer. The next item is taken in the cycle after that, so only
// one item is in flight at a time under the single shared sequencer. Lookups
// index the table with pc bits above bit 1 masked to ENTRIES-1; since a
// resolve carries a four bit index, only the lowest sixteen entries can ever
// be filled and only those are stored. Entries come up empty after reset with
// no clearing pass.
// -----------------------------------------------------------------------------
module branch_target_buffer_predictor_unit #(
   parameter int unsigned ENTRIES = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_op,
   input  logic [btbp_pkg::ADDR_W-1:0]            req_pc,
   input  logic                                   req_pc_write_enable,
   input  logic                                   req_is_branch,
   input  logic                                   req_predicted_found,
   input  logic [btbp_pkg::IDX_OUT_W-1:0]         req_entry_index,
   input  logic [btbp_pkg::ADDR_W-1:0]            req_fall_through_pc,
   input  logic signed [btbp_pkg::OFFSET_W-1:0]   req_branch_offset,
   input  logic                                   req_taken,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_found,
   output logic [btbp_pkg::IDX_OUT_W-1:0]         rsp_index_out,
   output logic [btbp_pkg::ADDR_W-1:0]            rsp_fall_through_out,
   output logic [btbp_pkg::ADDR_W-1:0]            rsp_next_pc,
   output logic                                   rsp_pc_update,
   output logic                                   rsp_flush,
   output logic [btbp_pkg::ADDR_W-1:0]            rsp_branch_total,
   output logic [btbp_pkg::ADDR_W-1:0]            rsp_hit_total,
   output logic [btbp_pkg::ADDR_W-1:0]            rsp_miss_total
);

   btbp_pkg::cmd_type cmd;

   btbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   btbp_datapath #(.ENTRIES(ENTRIES)) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_op               (req_op),
      .req_pc               (req_pc),
      .req_pc_write_enable  (req_pc_write_enable),
      .req_is_branch        (req_is_branch),
      .req_predicted_found  (req_predicted_found),
      .req_entry_index      (req_entry_index),
      .req_fall_through_pc  (req_fall_through_pc),
      .req_branch_offset    (req_branch_offset),
      .req_taken            (req_taken),
      .rsp_found            (rsp_found),
      .rsp_index_out        (rsp_index_out),
      .rsp_fall_through_out (rsp_fall_through_out),
      .rsp_next_pc          (rsp_next_pc),
      .rsp_pc_update        (rsp_pc_update),
      .rsp_flush            (rsp_flush),
      .rsp_branch_total     (rsp_branch_total),
      .rsp_hit_total        (rsp_hit_total),
      .rsp_miss_total       (rsp_miss_total)
   );

endmodule

FILE: design/btbp_ram.sv
// -----------------------------------------------------------------------------
// btbp_ram
// generic single write port ram with registered read
// -----------------------------------------------------------------------------
module btbp_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/btbp_ctrl.sv
// -----------------------------------------------------------------------------
// btbp_ctrl
// item sequencer: accept, execute, present result until transfer
// -----------------------------------------------------------------------------
module btbp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output btbp_pkg::cmd_type cmd
);

   btbp_pkg::state_type state_ff;
   btbp_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= btbp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         btbp_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = btbp_pkg::ST_EXEC;
            end
         end
         btbp_pkg::ST_EXEC: begin
            state_in = btbp_pkg::ST_DONE;
         end
         btbp_pkg::ST_DONE: begin
            if (!rsp_stall) begin
               state_in = btbp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = btbp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         btbp_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         btbp_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         btbp_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // one item in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("input open while a result is pending");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> cmd.exec)
      else $error("accepted item not executed next cycle");

   assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid)
      else $error("executed item did not produce a result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid && !req_stall)
      else $error("result repeated after transfer");

endmodule

FILE: design/btbp_datapath.sv
// -----------------------------------------------------------------------------
// btbp_datapath
// tag and target tables, valid bits, prediction and statistics
// -----------------------------------------------------------------------------
module btbp_datapath #(
   parameter int unsigned ENTRIES = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  btbp_pkg::cmd_type                      cmd,
   input  logic                                   req_op,
   input  logic [btbp_pkg::ADDR_W-1:0]            req_pc,
   input  logic                                   req_pc_write_enable,
   input  logic                                   req_is_branch,
   input  logic                                   req_predicted_found,
   input  logic [btbp_pkg::IDX_OUT_W-1:0]         req_entry_index,
   input  logic [btbp_pkg::ADDR_W-1:0]            req_fall_through_pc,
   input  logic signed [btbp_pkg::OFFSET_W-1:0]   req_branch_offset,
   input  logic                                   req_taken,
   output logic                                   rsp_found,
   output logic [btbp_pkg::IDX_OUT_W-1:0]         rsp_index_out,
   output logic [btbp_pkg::ADDR_W-1:0]            rsp_fall_through_out,
   output logic [btbp_pkg::ADDR_W-1:0]            rsp_next_pc,
   output logic                                   rsp_pc_update,
   output logic                                   rsp_flush,
   output logic [btbp_pkg::ADDR_W-1:0]            rsp_branch_total,
   output logic [btbp_pkg::ADDR_W-1:0]            rsp_hit_total,
   output logic [btbp_pkg::ADDR_W-1:0]            rsp_miss_total
);

   // resolve index is four bits wide, so only the low entries can ever be filled
   localparam int unsigned DEPTH = (ENTRIES < btbp_pkg::STORE_MAX) ?
                                   ENTRIES : btbp_pkg::STORE_MAX;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned AWD   = btbp_pkg::ADDR_W;
   localparam int unsigned IW    = btbp_pkg::IDX_OUT_W;
   localparam logic [AWD-1:0] IDX_MASK = AWD'(ENTRIES - 1);

   // lookup index
   logic [AWD-1:0] look_idx;
   logic           look_in_store;
   logic [IW-1:0]  eidx_masked;

   assign look_idx      = (req_pc >> 2) & IDX_MASK;
   assign look_in_store = (look_idx[AWD-1:IW] == '0);
   assign eidx_masked   = req_entry_index & IDX_MASK[IW-1:0];

   // captured item
   logic                                 op_ff;
   logic [AWD-1:0]                       pc_ff;
   logic                                 we_ff;
   logic                                 is_br_ff;
   logic                                 pfound_ff;
   logic [IW-1:0]                        idx_ff;
   logic [AW-1:0]                        addr_ff;
   logic                                 in_store_ff;
   logic [AWD-1:0]                       ft_ff;
   logic signed [btbp_pkg::OFFSET_W-1:0] off_ff;
   logic                                 tk_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_op;
         pc_ff     <= req_pc;
         we_ff     <= req_pc_write_enable;
         is_br_ff  <= req_is_branch;
         pfound_ff <= req_predicted_found;
         ft_ff     <= req_fall_through_pc;
         off_ff    <= req_branch_offset;
         tk_ff     <= req_taken;
         if (req_op == btbp_pkg::OP_LOOKUP) begin
            idx_ff      <= look_idx[IW-1:0];
            addr_ff     <= look_idx[AW-1:0];
            in_store_ff <= look_in_store;
         end else begin
            idx_ff      <= eidx_masked;
            addr_ff     <= eidx_masked[AW-1:0];
            in_store_ff <= 1'b1;
         end
      end
   end

   // tables
   logic [AWD-1:0] tag_rd;
   logic [AWD-1:0] target_rd;
   logic           tbl_wr;
   logic [AWD-1:0] tgt;
   logic [AWD-1:0] off_ext;

   assign off_ext = AWD'(off_ff);
   assign tgt     = ft_ff + (off_ext << 2);

   btbp_ram #(.WIDTH(AWD), .DEPTH(DEPTH)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (addr_ff),
      .wr_data (ft_ff - btbp_pkg::PC_STEP),
      .rd_en   (cmd.load),
      .rd_addr (look_idx[AW-1:0]),
      .rd_data (tag_rd)
   );

   btbp_ram #(.WIDTH(AWD), .DEPTH(DEPTH)) u_target_ram (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (addr_ff),
      .wr_data (tgt),
      .rd_en   (cmd.load),
      .rd_addr (look_idx[AW-1:0]),
      .rd_data (target_rd)
   );

   // valid bits
   logic [DEPTH-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (tbl_wr) begin
         valid_ff[addr_ff] <= 1'b1;
      end
   end

   // result
   logic           found_in;
   logic [AWD-1:0] npc_in;
   logic           upd_in;
   logic           flush_in;
   logic           br_inc;
   logic           hit_inc;
   logic           miss_inc;
   logic [AWD-1:0] pc_inc;

   assign pc_inc = pc_ff + btbp_pkg::PC_STEP;

   always_comb begin
      found_in = 1'b0;
      npc_in   = '0;
      upd_in   = 1'b0;
      flush_in = 1'b0;
      br_inc   = 1'b0;
      hit_inc  = 1'b0;
      miss_inc = 1'b0;
      tbl_wr   = 1'b0;
      if (op_ff == btbp_pkg::OP_LOOKUP) begin
         found_in = in_store_ff && valid_ff[addr_ff] && (tag_rd == pc_ff);
         npc_in   = found_in ? target_rd : pc_inc;
         upd_in   = we_ff;
      end else if (is_br_ff) begin
         br_inc = 1'b1;
         priority if (pfound_ff && tk_ff) begin
            hit_inc = 1'b1;
         end else if (pfound_ff) begin
            miss_inc = 1'b1;
            npc_in   = ft_ff;
            upd_in   = we_ff;
            flush_in = 1'b1;
         end else if (tk_ff) begin
            miss_inc = 1'b1;
            tbl_wr   = cmd.exec;
            npc_in   = tgt;
            upd_in   = we_ff;
            flush_in = 1'b1;
         end else begin
            hit_inc = 1'b1;
         end
      end
   end

   // statistics
   logic [AWD-1:0] br_cnt_ff,   br_cnt_in;
   logic [AWD-1:0] hit_cnt_ff,  hit_cnt_in;
   logic [AWD-1:0] miss_cnt_ff, miss_cnt_in;

   assign br_cnt_in   = br_cnt_ff   + AWD'(br_inc);
   assign hit_cnt_in  = hit_cnt_ff  + AWD'(hit_inc);
   assign miss_cnt_in = miss_cnt_ff + AWD'(miss_inc);

   always_ff @(posedge clock) begin
      if (reset) begin
         br_cnt_ff   <= '0;
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
      end else if (cmd.exec) begin
         br_cnt_ff   <= br_cnt_in;
         hit_cnt_ff  <= hit_cnt_in;
         miss_cnt_ff <= miss_cnt_in;
      end
   end

   // output register
   logic           found_ff;
   logic [IW-1:0]  index_ff;
   logic [AWD-1:0] ft_out_ff;
   logic [AWD-1:0] npc_ff;
   logic           upd_ff;
   logic           flush_ff;

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         found_ff  <= found_in;
         index_ff  <= idx_ff;
         ft_out_ff <= (op_ff == btbp_pkg::OP_LOOKUP) ? pc_inc : '0;
         npc_ff    <= npc_in;
         upd_ff    <= upd_in;
         flush_ff  <= flush_in;
      end
   end

   assign rsp_found            = found_ff;
   assign rsp_index_out        = index_ff;
   assign rsp_fall_through_out = ft_out_ff;
   assign rsp_next_pc          = npc_ff;
   assign rsp_pc_update        = upd_ff;
   assign rsp_flush            = flush_ff;
   assign rsp_branch_total     = br_cnt_ff;
   assign rsp_hit_total        = hit_cnt_ff;
   assign rsp_miss_total       = miss_cnt_ff;

   // every counted branch is either a hit or a miss
   assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> (br_cnt_ff - $past(br_cnt_ff)) ==
                   ((hit_cnt_ff - $past(hit_cnt_ff)) + (miss_cnt_ff - $past(miss_cnt_ff))))
      else $error("branch count out of step with hit and miss counts");

   assert property (@(posedge clock) disable iff (reset)
      cmd.exec && flush_in |-> miss_inc)
      else $error("flush without a miss");

endmodule
